@@ hdl/vdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types, codes and helpers of the Verlet distance constraint block.
// ----------------------------------------------------------------------------
package vdc_pkg;

  localparam int POS_W  = 32;
  localparam int WGT_W  = 16;
  localparam int IDX_W  = 10;
  localparam int REST_W = 63;
  localparam int TOL_W  = 32;
  localparam int MUL_W  = 34;
  localparam int FRAC_W = 17;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_SATISFY = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [TOL_W-1:0]  TOL_RESET = 32'd1;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [WGT_W-1:0]        wgt;
    logic                    att;
  } particle_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDA, ST_RDB, ST_CAPB, ST_SQ, ST_SQE, ST_CHK,
    ST_DIV, ST_MF, ST_MW, ST_UPD, ST_WRA, ST_WRB, ST_DONE
  } state_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[POS_W-1:0];
  endfunction

  // effective weight: ten times stored weight, once if attached
  function automatic logic [19:0] eff_wgt(input logic [WGT_W-1:0] w, input logic att);
    logic [19:0] wx;
    wx = {4'd0, w};
    return att ? wx : (wx << 3) + (wx << 1);
  endfunction

endpackage

@@ hdl/vdc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_in_if
// Input channel: operation and particle / constraint payload.
// ----------------------------------------------------------------------------
interface vdc_in_if;
  import vdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [IDX_W-1:0]         index_a;
  logic [IDX_W-1:0]         index_b;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic [WGT_W-1:0]         inverse_weight;
  logic                     attached;
  logic [REST_W-1:0]        rest_length_sq;

  modport source (output valid, operation, index_a, index_b, pos_x, pos_y, pos_z,
                  inverse_weight, attached, rest_length_sq, input ready);
  modport sink (input valid, operation, index_a, index_b, pos_x, pos_y, pos_z,
                inverse_weight, attached, rest_length_sq, output ready);
endinterface

@@ hdl/vdc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_out_if
// Result channel: position of particle A and changed flag.
// ----------------------------------------------------------------------------
interface vdc_out_if;
  import vdc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [POS_W-1:0] out_z;
  logic                    changed;

  modport source (output valid, out_x, out_y, out_z, changed, input ready);
  modport sink (input valid, out_x, out_y, out_z, changed, output ready);
endinterface

@@ hdl/vdc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_store
// Particle memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module vdc_store
  import vdc_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  particle_t     wdata,
  input  logic [AW-1:0] raddr,
  output particle_t     rdata
);

  particle_t mem [DEPTH];
  particle_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/vdc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module vdc_mul
  import vdc_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  logic signed [2*MUL_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

@@ hdl/vdc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_div
// Radix-2 fraction divider: floor(num * 2^16 / den) for num < den, else 1.0; one bit per cycle.
// ----------------------------------------------------------------------------
module vdc_div
  import vdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [63:0]       den,
  output logic              busy,
  output logic [FRAC_W-1:0] q
);

  logic              busy_r, busy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [63:0]       den_r, den_nxt;
  logic [FRAC_W-1:0] q_r, q_nxt;
  logic [64:0]       sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    sh       = {rem_r, 1'b0};
    if (start) begin
      den_nxt = den;
      rem_nxt = num;
      cnt_nxt = 4'd0;
      if (num >= den) begin
        q_nxt    = FRAC_ONE;
        busy_nxt = 1'b0;
      end else begin
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (sh[64] || sh[63:0] >= den_r) begin
        rem_nxt = sh[63:0] - den_r;
        q_nxt   = {q_r[FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[63:0];
        q_nxt   = {q_r[FRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign q    = q_r;

endmodule

@@ hdl/verlet_distance_constraint.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verlet_distance_constraint
// Particle store with a sqrt-free distance constraint projection.
// ----------------------------------------------------------------------------
// in_ch carries one item: write, read or satisfy between particles A and B.
// out_ch returns one item per input: position of A after the item, changed.
// cfg_we / cfg_wdata write tolerance_sq (reset value 1); the user must do
// so only while idle, the block does not enforce it. Items run one at a
// time through a one-read, one-write particle memory. Write and the unused
// operation go straight to the final state; read passes through ST_RDA and
// ST_RDB. Satisfy runs two memory reads, three squares on the shared
// multiplier, two 16-step dividers running side by side, six multiplies for
// the moves and two write-backs. A satisfy skipped by tolerance or zero
// weights ends after the squares. A new item is accepted once the previous
// one sits in the output register, so a stalled receiver holds only the
// result register; the next item completes but waits in the final state
// until the output is taken. Reset clears control state only; particle
// entries are undefined until written.
// ----------------------------------------------------------------------------
module verlet_distance_constraint
  import vdc_pkg::*;
#(
  parameter int PARTICLES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  vdc_in_if.sink           in_ch,
  vdc_out_if.source        out_ch
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int MW = (AW > IDX_W) ? AW : IDX_W;

  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] i);
    logic [MW+17:0] r;
    logic [MW+17:0] m;
    r = (MW+18)'(i);
    for (int k = MW - 1; k >= 0; k--) begin
      m = (MW+18)'(PARTICLES) << k;
      if (r >= m) r = r - m;
    end
    return r[AW-1:0];
  endfunction

  state_t st_r, st_nxt;
  logic [1:0]               op_r, op_nxt;
  logic [AW-1:0]            ia_r, ia_nxt, ib_r, ib_nxt;
  logic [REST_W-1:0]        rest_r, rest_nxt;
  logic [TOL_W-1:0]         tol_r;
  logic signed [POS_W-1:0]  pa_r [3];
  logic signed [POS_W-1:0]  pa_nxt [3];
  logic signed [POS_W-1:0]  pb_r [3];
  logic signed [POS_W-1:0]  pb_nxt [3];
  logic signed [32:0]       d_r [3];
  logic signed [32:0]       d_nxt [3];
  logic [WGT_W-1:0]         wa_r, wa_nxt, wb_r, wb_nxt;
  logic                     aa_r, aa_nxt, ab_r, ab_nxt;
  logic [19:0]              e1_r, e1_nxt, e2_r, e2_nxt;
  logic [63:0]              dist_r, dist_nxt;
  logic [1:0]               k_r, k_nxt;
  logic signed [17:0]       fac_r, fac_nxt;
  logic [FRAC_W-1:0]        w1_r, w1_nxt;
  logic signed [MUL_W-1:0]  s_r, s_nxt;
  logic                     dz_r, dz_nxt;
  logic                     chg_r, chg_nxt;
  logic                     ov_r, ov_nxt;
  logic signed [POS_W-1:0]  ox_r, oy_r, oz_r;
  logic                     oc_r;
  logic                     load_out;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  particle_t                mem_wdata, mem_rdata;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod;

  logic              div_start;
  logic [63:0]       divf_num, divf_den;
  logic              divf_busy, divw_busy;
  logic [FRAC_W-1:0] divf_q, divw_q;

  // combinational helpers
  logic [32:0]        mag;
  logic [1:0]         acc_k;
  logic               acc_sat;
  logic [63:0]        sqv;
  logic [64:0]        acc_sum;
  logic [63:0]        acc;
  logic [63:0]        rest64, diff, n_v, m_v;
  logic [64:0]        nm_sum;
  logic               run;
  logic signed [2*MUL_W-1:0] pc;
  logic signed [MUL_W-1:0]   m1, cm;
  logic signed [34:0]        m2;
  logic                      accept;

  vdc_store #(.DEPTH(PARTICLES), .AW(AW)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  vdc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  vdc_div u_div_f (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(divf_num), .den(divf_den),
    .busy(divf_busy), .q(divf_q)
  );

  vdc_div u_div_w (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num({44'd0, e1_r}),
    .den({43'd0, {1'b0, e1_r} + {1'b0, e2_r}}), .busy(divw_busy), .q(divw_q)
  );

  assign in_ch.ready = (st_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ov_r  <= 1'b0;
      tol_r <= TOL_RESET;
      k_r   <= 2'd0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      k_r  <= k_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
    op_r   <= op_nxt;
    ia_r   <= ia_nxt;
    ib_r   <= ib_nxt;
    rest_r <= rest_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    d_r    <= d_nxt;
    wa_r   <= wa_nxt;
    wb_r   <= wb_nxt;
    aa_r   <= aa_nxt;
    ab_r   <= ab_nxt;
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    dist_r <= dist_nxt;
    fac_r  <= fac_nxt;
    w1_r   <= w1_nxt;
    s_r    <= s_nxt;
    dz_r   <= dz_nxt;
    chg_r  <= chg_nxt;
    if (load_out) begin
      ox_r <= pa_r[0];
      oy_r <= pa_r[1];
      oz_r <= pa_r[2];
      oc_r <= chg_r;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    ia_nxt   = ia_r;
    ib_nxt   = ib_r;
    rest_nxt = rest_r;
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    d_nxt    = d_r;
    wa_nxt   = wa_r;
    wb_nxt   = wb_r;
    aa_nxt   = aa_r;
    ab_nxt   = ab_r;
    e1_nxt   = e1_r;
    e2_nxt   = e2_r;
    dist_nxt = dist_r;
    k_nxt    = k_r;
    fac_nxt  = fac_r;
    w1_nxt   = w1_r;
    s_nxt    = s_r;
    dz_nxt   = dz_r;
    chg_nxt  = chg_r;
    load_out = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = ia_r;
    mem_wdata = '{x: pa_r[0], y: pa_r[1], z: pa_r[2], wgt: wa_r, att: aa_r};
    mem_raddr = ia_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;

    // squared-length accumulation of the previous axis
    mag     = d_r[k_r][32] ? 33'(-d_r[k_r]) : 33'(d_r[k_r]);
    acc_k   = (st_r == ST_SQE) ? 2'd2 : k_r - 2'd1;
    acc_sat = d_r[acc_k][32] && (d_r[acc_k][31:0] == 32'd0);
    sqv     = acc_sat ? '1 : prod[63:0];
    acc_sum = {1'b0, dist_r} + {1'b0, sqv};
    acc     = acc_sum[64] ? '1 : acc_sum[63:0];

    // tolerance test and denominator scaling
    rest64 = {1'b0, rest_r};
    diff   = (rest64 > dist_r) ? rest64 - dist_r : dist_r - rest64;
    run    = (diff >= {32'd0, tol_r}) && ((e1_r != 20'd0) || (e2_r != 20'd0));
    nm_sum = {1'b0, rest64} + {1'b0, dist_r};
    n_v    = nm_sum[64] ? rest64 >> 1 : rest64;
    m_v    = nm_sum[64] ? dist_r >> 1 : dist_r;
    divf_num = n_v;
    divf_den = n_v + m_v;

    // position move of one axis
    pc = prod + 68'sd65535;
    m1 = prod[49:16];
    cm = pc[49:16];
    m2 = {s_r[MUL_W-1], s_r} - {cm[MUL_W-1], cm};

    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt   = in_ch.operation;
          ia_nxt   = wrap_idx(in_ch.index_a);
          ib_nxt   = wrap_idx(in_ch.index_b);
          rest_nxt = in_ch.rest_length_sq;
          chg_nxt  = 1'b0;
          case (in_ch.operation)
            OP_WRITE: begin
              mem_we    = 1'b1;
              mem_waddr = wrap_idx(in_ch.index_a);
              mem_wdata = '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z,
                            wgt: in_ch.inverse_weight, att: in_ch.attached};
              pa_nxt[0] = in_ch.pos_x;
              pa_nxt[1] = in_ch.pos_y;
              pa_nxt[2] = in_ch.pos_z;
              st_nxt    = ST_DONE;
            end
            OP_SATISFY, OP_READ: begin
              st_nxt = ST_RDA;
            end
            default: begin
              pa_nxt[0] = '0;
              pa_nxt[1] = '0;
              pa_nxt[2] = '0;
              st_nxt    = ST_DONE;
            end
          endcase
        end
      end
      ST_RDA: begin
        st_nxt = ST_RDB;
      end
      ST_RDB: begin
        mem_raddr = ib_r;
        pa_nxt[0] = mem_rdata.x;
        pa_nxt[1] = mem_rdata.y;
        pa_nxt[2] = mem_rdata.z;
        wa_nxt    = mem_rdata.wgt;
        aa_nxt    = mem_rdata.att;
        e1_nxt    = eff_wgt(mem_rdata.wgt, mem_rdata.att);
        st_nxt    = (op_r == OP_READ) ? ST_DONE : ST_CAPB;
      end
      ST_CAPB: begin
        pb_nxt[0] = mem_rdata.x;
        pb_nxt[1] = mem_rdata.y;
        pb_nxt[2] = mem_rdata.z;
        wb_nxt    = mem_rdata.wgt;
        ab_nxt    = mem_rdata.att;
        e2_nxt    = eff_wgt(mem_rdata.wgt, mem_rdata.att);
        d_nxt[0]  = {pa_r[0][31], pa_r[0]} - {mem_rdata.x[31], mem_rdata.x};
        d_nxt[1]  = {pa_r[1][31], pa_r[1]} - {mem_rdata.y[31], mem_rdata.y};
        d_nxt[2]  = {pa_r[2][31], pa_r[2]} - {mem_rdata.z[31], mem_rdata.z};
        k_nxt     = 2'd0;
        st_nxt    = ST_SQ;
      end
      ST_SQ: begin
        mul_a    = {2'b00, mag[31:0]};
        mul_b    = {2'b00, mag[31:0]};
        dist_nxt = (k_r == 2'd0) ? 64'd0 : acc;
        if (k_r == 2'd2) begin
          k_nxt  = 2'd0;
          st_nxt = ST_SQE;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_SQE: begin
        dist_nxt = acc;
        st_nxt   = ST_CHK;
      end
      ST_CHK: begin
        dz_nxt = (divf_den == 64'd0);
        if (run) begin
          div_start = 1'b1;
          st_nxt    = ST_DIV;
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (!divf_busy && !divw_busy) begin
          fac_nxt = dz_r ? 18'sd0 : $signed({1'b0, divf_q}) - 18'sd32768;
          w1_nxt  = divw_q;
          k_nxt   = 2'd0;
          st_nxt  = ST_MF;
        end
      end
      ST_MF: begin
        mul_a  = {d_r[k_r][32], d_r[k_r]};
        mul_b  = {{16{fac_r[17]}}, fac_r};
        st_nxt = ST_MW;
      end
      ST_MW: begin
        s_nxt  = prod[49:16];
        mul_a  = prod[49:16];
        mul_b  = {17'd0, w1_r};
        st_nxt = ST_UPD;
      end
      ST_UPD: begin
        pa_nxt[k_r] = sat32({{4{pa_r[k_r][31]}}, pa_r[k_r]} + {{2{m1[MUL_W-1]}}, m1});
        pb_nxt[k_r] = sat32({{4{pb_r[k_r][31]}}, pb_r[k_r]} - {m2[34], m2});
        if (k_r == 2'd2) begin
          k_nxt  = 2'd0;
          st_nxt = ST_WRA;
        end else begin
          k_nxt  = k_r + 2'd1;
          st_nxt = ST_MF;
        end
      end
      ST_WRA: begin
        mem_we = 1'b1;
        st_nxt = ST_WRB;
      end
      ST_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = ib_r;
        mem_wdata = '{x: pb_r[0], y: pb_r[1], z: pb_r[2], wgt: wb_r, att: ab_r};
        chg_nxt   = 1'b1;
        st_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.out_x   = ox_r;
  assign out_ch.out_y   = oy_r;
  assign out_ch.out_z   = oz_r;
  assign out_ch.changed = oc_r;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Verlet distance constraint block.
// ----------------------------------------------------------------------------
// A queue-fed driver offers write, read, satisfy and unused-operation items
// with random gaps. A monitor with random stalls takes the results and checks
// them in order against a fixed-point projection predictor that keeps its own
// particle store. The bench runs several tolerance settings, including zero
// and full scale, and holds the receiver off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import vdc_pkg::*;

  typedef struct {
    logic [1:0]              op;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [WGT_W-1:0]        w;
    logic                    att;
    logic [REST_W-1:0]       rest;
  } particle_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    changed;
  } pos_result_t;

  localparam int LIMIT_CYCLES = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  vdc_in_if  in_ch ();
  vdc_out_if out_ch ();

  verlet_distance_constraint u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [POS_W-1:0] pos_store [1024][3];
  logic [WGT_W-1:0]        wgt_store [1024];
  logic                    att_store [1024];
  logic [TOL_W-1:0]        tol_model;

  // stimulus bookkeeping
  particle_op_t pending_ops[$];
  pos_result_t  expected_pos[$];
  bit           written_map [1024];
  int           written_list[$];

  int  cycle_cnt = 0;
  int  mismatches = 0;
  int  checked = 0;
  int  moved_cnt = 0;
  int  op_cnt [4];
  bit  taken = 1'b0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  want_hold = 1'b0;
  bit  hold_done = 1'b0;

  function automatic logic [16:0] frac_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [16:0] q;
    logic        top;
    if (num >= den) return 17'h10000;
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      top = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (top || rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pos_result_t project_item(particle_op_t it);
    pos_result_t r;
    longint      d [3];
    longint      s, m1, m2, factor;
    logic [63:0] dsq, sq, mag, diff, n, m, e1, e2;
    logic [16:0] w1, w2;
    r.changed = 1'b0;
    if (it.op == OP_NONE) begin
      r.x = '0; r.y = '0; r.z = '0;
      return r;
    end
    if (it.op == OP_WRITE) begin
      pos_store[it.a][0] = it.x;
      pos_store[it.a][1] = it.y;
      pos_store[it.a][2] = it.z;
      wgt_store[it.a] = it.w;
      att_store[it.a] = it.att;
    end else if (it.op == OP_SATISFY) begin
      dsq = '0;
      for (int k = 0; k < 3; k++) begin
        d[k] = longint'(pos_store[it.a][k]) - longint'(pos_store[it.b][k]);
        mag = d[k] < 0 ? -d[k] : d[k];
        sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
        dsq = (dsq > ~sq) ? '1 : dsq + sq;
      end
      n = {1'b0, it.rest};
      diff = n > dsq ? n - dsq : dsq - n;
      if (diff >= {32'd0, tol_model}) begin
        e1 = wgt_store[it.a] * (att_store[it.a] ? 64'd1 : 64'd10);
        e2 = wgt_store[it.b] * (att_store[it.b] ? 64'd1 : 64'd10);
        if (e1 != 0 || e2 != 0) begin
          m = dsq;
          if (m > ~n) begin
            n = n >> 1;
            m = m >> 1;
          end
          if (n + m == 0) factor = 0;
          else factor = longint'(frac_q16(n, n + m)) - 32768;
          w1 = frac_q16(e1, e1 + e2);
          w2 = 17'h10000 - w1;
          for (int k = 0; k < 3; k++) begin
            s = (d[k] * factor) >>> 16;
            m1 = (s * longint'(w1)) >>> 16;
            m2 = (s * longint'(w2)) >>> 16;
            pos_store[it.a][k] = clamp32(longint'(pos_store[it.a][k]) + m1);
            pos_store[it.b][k] = clamp32(longint'(pos_store[it.b][k]) - m2);
          end
          r.changed = 1'b1;
        end
      end
    end
    r.x = pos_store[it.a][0];
    r.y = pos_store[it.a][1];
    r.z = pos_store[it.a][2];
    return r;
  endfunction

  // input and output side: acceptance, prediction and result checks at the rising edge
  always @(posedge clk) begin
    particle_op_t cur;
    pos_result_t  got, exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cur.op = in_ch.operation;
      cur.a = in_ch.index_a;
      cur.b = in_ch.index_b;
      cur.x = in_ch.pos_x;
      cur.y = in_ch.pos_y;
      cur.z = in_ch.pos_z;
      cur.w = in_ch.inverse_weight;
      cur.att = in_ch.attached;
      cur.rest = in_ch.rest_length_sq;
      expected_pos.push_back(project_item(cur));
      op_cnt[cur.op]++;
      taken = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.out_x;
      got.y = out_ch.out_y;
      got.z = out_ch.out_z;
      got.changed = out_ch.changed;
      checked++;
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item x=%h y=%h z=%h changed=%b",
                                       got.x, got.y, got.z, got.changed);
      end else begin
        exp_r = expected_pos.pop_front();
        if (exp_r.changed) moved_cnt++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch item %0d: exp x=%h y=%h z=%h ch=%b got x=%h y=%h z=%h ch=%b",
                     checked, exp_r.x, exp_r.y, exp_r.z, exp_r.changed,
                     got.x, got.y, got.z, got.changed);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    particle_op_t it;
    int r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (taken || !in_ch.valid) begin
      taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        it = pending_ops.pop_front();
        in_ch.operation <= it.op;
        in_ch.index_a <= it.a;
        in_ch.index_b <= it.b;
        in_ch.pos_x <= it.x;
        in_ch.pos_y <= it.y;
        in_ch.pos_z <= it.z;
        in_ch.inverse_weight <= it.w;
        in_ch.attached <= it.att;
        in_ch.rest_length_sq <= it.rest;
        in_ch.valid <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 60) send_gap = 0;
        else if (r < 92) send_gap = $urandom_range(1, 3);
        else send_gap = $urandom_range(8, 30);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int r;
    if (want_hold && !hold_done) begin
      hold_done = 1'b1;
      recv_stall = 400;
    end
    if (recv_stall > 0) begin
      recv_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r >= 70 && r < 95) recv_stall = $urandom_range(1, 3);
      else if (r >= 95) recv_stall = $urandom_range(10, 40);
    end
  end

  function automatic particle_op_t rand_fields();
    particle_op_t it;
    it.op = OP_NONE;
    it.a = IDX_W'($urandom);
    it.b = IDX_W'($urandom);
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.w = WGT_W'($urandom);
    it.att = 1'($urandom);
    it.rest = REST_W'({$urandom, $urandom});
    return it;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    int sh;
    logic signed [POS_W-1:0] v;
    if ($urandom_range(0, 99) < 15) return $urandom;
    sh = $urandom_range(8, 24);
    v = $urandom_range(0, (1 << sh) - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic add_op(particle_op_t it);
    if (it.op == OP_WRITE && !written_map[it.a]) begin
      written_map[it.a] = 1'b1;
      written_list.push_back(it.a);
    end
    pending_ops.push_back(it);
  endtask

  function automatic logic [IDX_W-1:0] pick_written();
    return IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic add_random(int count);
    particle_op_t it;
    int r;
    repeat (count) begin
      it = rand_fields();
      r = $urandom_range(0, 99);
      if (written_list.size() < 2 || r < 25) begin
        it.op = OP_WRITE;
        if ($urandom_range(0, 99) < 80) it.a = IDX_W'($urandom_range(0, 15));
        it.x = rand_pos();
        it.y = rand_pos();
        it.z = rand_pos();
        r = $urandom_range(0, 99);
        if (r < 20) it.w = '0;
        else if (r < 50) it.w = WGT_W'($urandom_range(1, 1024));
      end else if (r < 80) begin
        it.op = OP_SATISFY;
        it.a = pick_written();
        it.b = ($urandom_range(0, 19) == 0) ? it.a : pick_written();
        if ($urandom_range(0, 9) != 0) it.rest = it.rest >> $urandom_range(0, 62);
      end else if (r < 95) begin
        it.op = OP_READ;
        it.a = pick_written();
      end
      add_op(it);
    end
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_ch.valid || expected_pos.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tol_model = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_directed();
    particle_op_t it;
    it = rand_fields();
    it.op = OP_WRITE; it.a = 0; it.x = 32'sh7fffffff; it.y = 32'sh7fffffff;
    it.z = 32'sh7fffffff; it.w = 16'hffff; it.att = 1'b0;
    add_op(it);
    it.op = OP_WRITE; it.a = 10'h3ff; it.x = 32'sh80000000; it.y = 32'sh80000000;
    it.z = 32'sh80000000; it.w = 16'hffff; it.att = 1'b1;
    add_op(it);
    it.op = OP_WRITE; it.a = 2; it.x = 32'sh00010000; it.y = '0; it.z = '0;
    it.w = '0; it.att = 1'b0;
    add_op(it);
    it.op = OP_WRITE; it.a = 3; it.x = '0; it.y = 32'sh00020000; it.z = -32'sh8000;
    it.w = '0; it.att = 1'b1;
    add_op(it);
    it.op = OP_WRITE; it.a = 4; it.x = 32'sh00030000; it.y = 32'sh00010000;
    it.z = '0; it.w = 16'h0100; it.att = 1'b0;
    add_op(it);
    it.op = OP_WRITE; it.a = 10'h2aa; it.x = 32'sh00030000; it.y = 32'sh00010000;
    it.z = '0; it.w = 16'h0100; it.att = 1'b0;
    add_op(it);
    it.op = OP_SATISFY; it.a = 0; it.b = 10'h3ff; it.rest = '1;
    add_op(it);
    it.op = OP_SATISFY; it.a = 0; it.b = 10'h3ff; it.rest = '0;
    add_op(it);
    it.op = OP_SATISFY; it.a = 2; it.b = 3; it.rest = 63'h4_0000_0000;
    add_op(it);
    it.op = OP_SATISFY; it.a = 4; it.b = 4; it.rest = 63'h9_0000_0000;
    add_op(it);
    it.op = OP_SATISFY; it.a = 4; it.b = 2; it.rest = 63'h1_0000_0000;
    add_op(it);
    it.op = OP_SATISFY; it.a = 3; it.b = 4; it.rest = 63'h100_0000_0000;
    add_op(it);
    it.op = OP_SATISFY; it.a = 4; it.b = 10'h2aa; it.rest = '0;
    add_op(it);
    it.op = OP_READ; it.a = 0;
    add_op(it);
    it.op = OP_READ; it.a = 10'h3ff;
    add_op(it);
    it = rand_fields(); it.op = OP_NONE;
    add_op(it);
    it = rand_fields(); it.op = OP_NONE; it.a = '1; it.b = '1;
    add_op(it);
  endtask

  initial begin
    particle_op_t it;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_NONE;
    in_ch.index_a = '0;
    in_ch.index_b = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.inverse_weight = '0;
    in_ch.attached = 1'b0;
    in_ch.rest_length_sq = '0;
    out_ch.ready = 1'b0;
    tol_model = TOL_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_directed();
    wait_idle();

    // zero tolerance: coincident particles with zero rest hit the zero denominator
    write_tolerance('0);
    it = rand_fields();
    it.op = OP_WRITE; it.a = 4; it.x = 32'sh00050000; it.y = '0; it.z = '0;
    it.w = 16'h0080; it.att = 1'b0;
    add_op(it);
    it.a = 10'h2aa;
    add_op(it);
    it.op = OP_SATISFY; it.a = 4; it.b = 10'h2aa; it.rest = '0;
    add_op(it);
    add_random(130);
    wait_idle();

    write_tolerance('1);
    want_hold = 1'b1;
    add_random(130);
    wait_idle();

    write_tolerance(32'h0001_0000);
    add_random(130);
    wait_idle();

    write_tolerance($urandom);
    add_random(130);
    wait_idle();

    write_tolerance(TOL_RESET);
    add_random(110);
    wait_idle();

    $display("ran %0d writes, %0d satisfies (%0d moved), %0d reads, %0d unused ops",
             op_cnt[OP_WRITE], op_cnt[OP_SATISFY], moved_cnt, op_cnt[OP_READ],
             op_cnt[OP_NONE]);
    $display("checked %0d items over six tolerance settings, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/vdc_pkg.sv
hdl/vdc_in_if.sv
hdl/vdc_out_if.sv
hdl/vdc_store.sv
hdl/vdc_mul.sv
hdl/vdc_div.sv
hdl/verlet_distance_constraint.sv
sim/tb_top.sv
